// ===== hdl/bpsm_pkg.sv =====
// Shared types and constants for the button press settings menu.
// Used by the channel interfaces, the register file, the core and the top level.
`default_nettype none

package bpsm_pkg;

  // Widths of state that follow from the design constants
  localparam int POSITION_BITS = 4;
  localparam int TIMER_BITS    = 16;

  // Fixed widths of the register fields
  localparam int LIMIT_BITS  = 16;
  localparam int COUNT_BITS  = 5;
  localparam int INDEX_BITS  = 3;
  localparam int DATA_BITS   = 16;
  localparam int TOGGLE_BITS = 4;

  // Compare widths wide enough for both operands
  localparam int CMP_BITS = (TIMER_BITS > LIMIT_BITS) ? TIMER_BITS : LIMIT_BITS;
  localparam int POS_LIMIT = 1 << POSITION_BITS;
  localparam int POS_CNT_BITS = (POSITION_BITS + 1 > COUNT_BITS) ? POSITION_BITS + 1
                                                                   : COUNT_BITS;

  // Blink counts for the three events
  localparam int BLINKS_STEP  = 1;
  localparam int BLINKS_ENTER = 3;
  localparam int BLINKS_EXIT  = 4;

  // Register reset values
  localparam logic [LIMIT_BITS-1:0] SHORT_LIMIT_RST = 16'd300;
  localparam logic [LIMIT_BITS-1:0] LONG_LIMIT_RST  = 16'd2000;
  localparam logic [LIMIT_BITS-1:0] IDLE_LIMIT_RST  = 16'd1000;
  localparam logic [COUNT_BITS-1:0] POS_COUNT_RST   = 5'd4;
  localparam logic [LIMIT_BITS-1:0] HALF_PERIOD_RST = 16'd200;

  // Register indexes on the configuration port
  typedef enum logic [INDEX_BITS-1:0] {
    REG_SHORT_LIMIT = 3'd0,
    REG_LONG_LIMIT  = 3'd1,
    REG_IDLE_LIMIT  = 3'd2,
    REG_POS_COUNT   = 3'd3,
    REG_HALF_PERIOD = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [LIMIT_BITS-1:0] short_limit;
    logic [LIMIT_BITS-1:0] long_limit;
    logic [LIMIT_BITS-1:0] idle_limit;
    logic [COUNT_BITS-1:0] position_count;
    logic [LIMIT_BITS-1:0] blink_half_period;
  } cfg_t;

  typedef struct packed {
    logic                     led_on;
    logic                     in_settings;
    logic [POSITION_BITS-1:0] menu_position;
    logic                     blinking;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/bpsm_if.sv =====
// Valid/ready channel interfaces: tick input, status output, register writes.
// Depends on bpsm_pkg for field widths.
`default_nettype none

interface bpsm_tick_if;
  logic valid;
  logic ready;
  logic button_pressed;
  modport source (output valid, output button_pressed, input ready);
  modport sink (input valid, input button_pressed, output ready);
endinterface

interface bpsm_status_if;
  import bpsm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     led_on;
  logic                     in_settings;
  logic [POSITION_BITS-1:0] menu_position;
  logic                     blinking;
  modport source (output valid, output led_on, output in_settings, output menu_position,
                  output blinking, input ready);
  modport sink (input valid, input led_on, input in_settings, input menu_position,
                input blinking, output ready);
endinterface

interface bpsm_cfg_if;
  import bpsm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] index;
  logic [DATA_BITS-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/bpsm_cfg_regs.sv =====
// Configuration register file, written over the configuration channel.
// Depends on bpsm_pkg and bpsm_cfg_if.
`default_nettype none

module bpsm_cfg_regs (
  input  wire logic        clk,
  input  wire logic        rst,
  bpsm_cfg_if.sink         cfg,
  output bpsm_pkg::cfg_t   regs
);
  import bpsm_pkg::*;

  // Always ready: every write is taken and registered
  assign cfg.ready = 1'b1;

  // Write the addressed register, drop writes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.short_limit       <= SHORT_LIMIT_RST;
      regs.long_limit        <= LONG_LIMIT_RST;
      regs.idle_limit        <= IDLE_LIMIT_RST;
      regs.position_count    <= POS_COUNT_RST;
      regs.blink_half_period <= HALF_PERIOD_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SHORT_LIMIT: regs.short_limit       <= cfg.data[LIMIT_BITS-1:0];
        REG_LONG_LIMIT:  regs.long_limit        <= cfg.data[LIMIT_BITS-1:0];
        REG_IDLE_LIMIT:  regs.idle_limit        <= cfg.data[LIMIT_BITS-1:0];
        REG_POS_COUNT:   regs.position_count    <= cfg.data[COUNT_BITS-1:0];
        REG_HALF_PERIOD: regs.blink_half_period <= cfg.data[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bpsm_core.sv =====
// Menu state and per-tick update: press timing, mode, position, blink sequencer.
// Depends on bpsm_pkg; the result is registered by the top level.
`default_nettype none

module bpsm_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step,
  input  wire logic           button,
  input  wire bpsm_pkg::cfg_t regs,
  output bpsm_pkg::result_t   result
);
  import bpsm_pkg::*;

  logic                     settings_mode, settings_mode_next;
  logic [POSITION_BITS-1:0] position, position_next;
  logic [TIMER_BITS-1:0]    press_elapsed, press_elapsed_next;
  logic                     press_armed, press_armed_next;
  logic                     button_last;
  logic                     led_level, led_level_next;
  logic [TOGGLE_BITS-1:0]   toggles_left, toggles_left_next;
  logic [LIMIT_BITS-1:0]    blink_timer, blink_timer_next;

  logic                     busy;
  logic [POS_CNT_BITS-1:0]  pos_cnt;
  logic [POS_CNT_BITS-1:0]  pos_inc;
  logic [POSITION_BITS-1:0] pos_adv;
  logic [LIMIT_BITS-1:0]    timer_inc;

  // Wrapped next menu position
  always_comb begin
    pos_cnt = POS_CNT_BITS'(regs.position_count);
    if (pos_cnt == '0) pos_cnt = POS_CNT_BITS'(1);
    if (pos_cnt > POS_CNT_BITS'(POS_LIMIT)) pos_cnt = POS_CNT_BITS'(POS_LIMIT);
    pos_inc = POS_CNT_BITS'(position) + POS_CNT_BITS'(1);
    pos_adv = (pos_inc >= pos_cnt) ? '0 : pos_inc[POSITION_BITS-1:0];
  end

  // Next state for one tick
  always_comb begin
    busy               = (toggles_left != '0);
    settings_mode_next = settings_mode;
    position_next      = position;
    press_elapsed_next = press_elapsed;
    press_armed_next   = press_armed;
    led_level_next     = led_level;
    toggles_left_next  = toggles_left;
    blink_timer_next   = blink_timer;
    timer_inc          = '0;

    // Restart the press timer on a press, else advance it with saturation while no blink plays
    if (button && !button_last) begin
      press_elapsed_next = '0;
      press_armed_next   = 1'b1;
    end else if (!busy && press_elapsed != '1) begin
      press_elapsed_next = press_elapsed + TIMER_BITS'(1);
    end

    // Decide on release, hold or idle while no blink plays
    if (!busy) begin
      if (!button) begin
        if (press_armed_next &&
            CMP_BITS'(press_elapsed_next) < CMP_BITS'(regs.short_limit)) begin
          if (!settings_mode) begin
            led_level_next = ~led_level;
          end else begin
            position_next     = pos_adv;
            toggles_left_next = TOGGLE_BITS'(BLINKS_STEP * 2);
            blink_timer_next  = '0;
          end
          press_armed_next = 1'b0;
        end else if (settings_mode &&
                     CMP_BITS'(press_elapsed_next) > CMP_BITS'(regs.idle_limit)) begin
          toggles_left_next  = TOGGLE_BITS'(BLINKS_EXIT * 2);
          blink_timer_next   = '0;
          settings_mode_next = 1'b0;
        end
      end else if (!settings_mode && press_armed_next &&
                   CMP_BITS'(press_elapsed_next) > CMP_BITS'(regs.long_limit)) begin
        toggles_left_next  = TOGGLE_BITS'(BLINKS_ENTER * 2);
        blink_timer_next   = '0;
        settings_mode_next = 1'b1;
        press_armed_next   = 1'b0;
        press_elapsed_next = '0;
      end
    end

    // Advance the blink sequencer: toggle at the start of each half period
    if (toggles_left_next != '0) begin
      if (blink_timer_next == '0) led_level_next = ~led_level_next;
      timer_inc = blink_timer_next + LIMIT_BITS'(1);
      if (timer_inc >= regs.blink_half_period) begin
        blink_timer_next  = '0;
        toggles_left_next = toggles_left_next - TOGGLE_BITS'(1);
      end else begin
        blink_timer_next = timer_inc;
      end
    end
  end

  // Result of this tick, taken from the updated state
  always_comb begin
    result.led_on        = led_level_next;
    result.in_settings   = settings_mode_next;
    result.menu_position = position_next;
    result.blinking      = (toggles_left_next != '0);
  end

  // Commit state on each tick beat
  always_ff @(posedge clk) begin
    if (rst) begin
      settings_mode <= 1'b0;
      position      <= '0;
      press_elapsed <= '0;
      press_armed   <= 1'b0;
      button_last   <= 1'b0;
      led_level     <= 1'b0;
      toggles_left  <= '0;
      blink_timer   <= '0;
    end else if (step) begin
      settings_mode <= settings_mode_next;
      position      <= position_next;
      press_elapsed <= press_elapsed_next;
      press_armed   <= press_armed_next;
      button_last   <= button;
      led_level     <= led_level_next;
      toggles_left  <= toggles_left_next;
      blink_timer   <= blink_timer_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/button_press_settings_menu.sv =====
// Top level of the button press settings menu: input register, core, status register.
// Depends on bpsm_pkg, the channel interfaces, bpsm_cfg_regs and bpsm_core.
//
// Usage:
//   tick   - one beat per millisecond tick, carrying the button level.
//   status - one beat per tick: LED level, settings mode, menu position and
//            whether a blink sequence is still playing, all after that tick.
//   cfg    - register writes (index 0..4); always ready, registered when taken.
//            Write only while no tick is in flight.
// Path: an accepted tick is registered at the input, processed by the core and
//   registered at the output once the status register is free or draining,
//   where its status beat is offered.
// Throughput: one tick per cycle while status is taken; the whole update is
//   one pass of logic between the input register and the status register.
// Reset: rst (synchronous) empties both registers, restores register defaults
//   and returns to normal mode, position zero, LED off.
// Stall: while status is not taken, the status beat holds; one more tick is
//   accepted into the input register, then tick.ready drops until status moves.
`default_nettype none

module button_press_settings_menu (
  input  wire logic      clk,
  input  wire logic      rst,
  bpsm_tick_if.sink      tick,
  bpsm_status_if.source  status,
  bpsm_cfg_if.sink       cfg
);
  import bpsm_pkg::*;

  logic    in_valid;
  logic    in_button;
  logic    fire;
  logic    out_valid;
  result_t out_result;
  result_t core_result;
  cfg_t    regs;

  bpsm_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  bpsm_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (fire),
    .button (in_button),
    .regs   (regs),
    .result (core_result)
  );

  // Process the held tick when the status register is free or draining
  assign fire       = in_valid && (!out_valid || status.ready);
  assign tick.ready = !in_valid || fire;

  // Hold the incoming tick beat
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.ready) begin
      in_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      in_button <= tick.button_pressed;
    end
  end

  // Register the status beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (status.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_result <= core_result;
    end
  end

  // Drive the status channel
  assign status.valid         = out_valid;
  assign status.led_on        = out_result.led_on;
  assign status.in_settings   = out_result.in_settings;
  assign status.menu_position = out_result.menu_position;
  assign status.blinking      = out_result.blinking;

endmodule

`default_nettype wire

// ===== hdl/bpsm_checker.sv =====
// Port-level checks for the button press settings menu, bound to the top level.
// Depends on bpsm_pkg for the position width.
`default_nettype none

module bpsm_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               tick_ready,
  input wire logic                               status_valid,
  input wire logic                               status_ready,
  input wire logic                               status_led_on,
  input wire logic                               status_in_settings,
  input wire logic [bpsm_pkg::POSITION_BITS-1:0] status_menu_position,
  input wire logic                               status_blinking
);
  import bpsm_pkg::*;

  logic                     prev_settings;
  logic [POSITION_BITS-1:0] prev_position;
  logic                     status_beat;

  assign status_beat = status_valid && status_ready;

  // Track the last delivered mode and position
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_settings <= 1'b0;
      prev_position <= '0;
    end else if (status_beat) begin
      prev_settings <= status_in_settings;
      prev_position <= status_menu_position;
    end
  end

  // Reset empties the status register
  a_reset_empty: assert property (@(posedge clk) rst |=> !status_valid)
    else $error("status valid after reset");

  // A stalled status beat holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    status_valid && !status_ready |=> status_valid && $stable(status_led_on) &&
      $stable(status_in_settings) && $stable(status_menu_position) &&
      $stable(status_blinking))
    else $error("stalled status beat changed");

  // Entering or leaving settings always starts a blink sequence
  a_mode_blinks: assert property (@(posedge clk) disable iff (rst)
    status_beat && (status_in_settings != prev_settings) |-> status_blinking)
    else $error("mode change without blink sequence");

  // The position moves only by a settings step, which blinks
  a_position_step: assert property (@(posedge clk) disable iff (rst)
    status_beat && (status_menu_position != prev_position) |->
      status_in_settings && status_blinking)
    else $error("position changed outside a settings step");

  // With no status pending, a tick is always taken
  a_tick_ready: assert property (@(posedge clk) disable iff (rst)
    !status_valid |-> tick_ready)
    else $error("tick stalled with empty status register");

endmodule

bind button_press_settings_menu bpsm_checker u_bpsm_checker (
  .clk                  (clk),
  .rst                  (rst),
  .tick_ready           (tick.ready),
  .status_valid         (status.valid),
  .status_ready         (status.ready),
  .status_led_on        (status.led_on),
  .status_in_settings   (status.in_settings),
  .status_menu_position (status.menu_position),
  .status_blinking      (status.blinking)
);

`default_nettype wire
